// ===== hw/rtl/assert_macros.svh =====
// shared concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define BLS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bls assertion failed");

// same, with a caller supplied message
`define BLS_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/bls_pkg.sv =====
package bls_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int DATA_W   = 32;
  localparam int OPC_W    = 3;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FAIL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

endpackage

// ===== hw/rtl/bounded_lifo_stack_with_search_core.sv =====
// Bounded LIFO stack of signed 32-bit words held in a synchronous RAM of
// DEPTH entries. Each input item carries an opcode in s_axis_tuser (push, pop, peek,
// clear, search) and a word in s_axis_tdata, and yields exactly one result item with
// status in m_axis_tuser and data, index, count, is_empty and is_full in m_axis_tdata.
// Items are handled one at a time and the RAM read port sets the timing: push, clear
// and unused opcodes go from idle straight to done, pop and peek pass the read state
// for their RAM read or go straight to done on an empty stack, and a search examines
// entries from the top down, one RAM read per cycle, at most DEPTH of them. A result
// sits in an output register, so the next item is accepted while an earlier result
// still waits on m_axis_tready; a further result waits in its done state until that
// register frees up. The user must write capacity through cfg_we_i / cfg_wdata_i
// only while the block is idle, which the block does not enforce; it saturates at DEPTH.
module bounded_lifo_stack_with_search_core
  import bls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CAP_W-1:0]    cfg_wdata_i,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DATA_W-1:0]   s_axis_tdata,   // [31:0] value
  input  logic [OPC_W-1:0]    s_axis_tuser,   // [2:0] opcode

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [31:0] data, [37:32] index, [44:38] count,
                                              // [45] is_empty, [46] is_full, [47] zero
  output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

  // control state
  fsm_e                 state_q, state_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [CAP_W-1:0]     cap_q;

  // per-item working registers
  logic [DATA_W-1:0]    key_q, key_d;
  logic [ADDR_W-1:0]    ptr_q, ptr_d;
  status_e              res_status_q, res_status_d;
  logic [DATA_W-1:0]    res_data_q, res_data_d;
  logic [INDEX_W-1:0]   res_index_q, res_index_d;

  // output register
  logic                 m_valid_q;
  status_e              m_status_q;
  logic [DATA_W-1:0]    m_data_q;
  logic [INDEX_W-1:0]   m_index_q;
  logic [COUNT_W-1:0]   m_count_q;
  logic                 m_empty_q;
  logic                 m_full_q;

  // stack ram
  logic [DATA_W-1:0]    mem_q [DEPTH];
  logic [DATA_W-1:0]    rd_data_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_raddr;

  logic                 in_fire;
  logic                 out_free;
  logic                 load_out;
  opcode_e              op_in;
  logic [COUNT_W-1:0]   limit;
  logic [ADDR_W-1:0]    top_addr;
  logic                 at_limit;
  logic                 key_hit;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign op_in    = opcode_e'(s_axis_tuser);

  // effective capacity saturates at the ram depth
  assign limit    = (cap_q > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : cap_q;
  assign at_limit = (count_q >= limit);
  // address of the current top entry, only used when the stack is not empty
  assign top_addr = ADDR_W'(count_q - 1'b1);
  // ram data belongs to the address issued on the previous cycle (ptr_q in scan)
  assign key_hit  = (rd_data_q == key_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          case (op_in)
            OP_POP, OP_PEEK: state_d = (count_q == '0) ? FSM_DONE : FSM_READ;
            OP_SEARCH:       state_d = (count_q == '0) ? FSM_DONE : FSM_SCAN;
            default:         state_d = FSM_DONE;
          endcase
        end
      end
      FSM_READ: state_d = FSM_DONE;
      FSM_SCAN: begin
        // stop on the topmost match or after the bottom entry
        if (key_hit || (ptr_q == '0)) begin
          state_d = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    s_axis_tready = (state_q == FSM_IDLE);
    mem_we        = 1'b0;
    mem_raddr     = ptr_q;
    count_d       = count_q;
    key_d         = key_q;
    ptr_d         = ptr_q;
    res_status_d  = res_status_q;
    res_data_d    = res_data_q;
    res_index_d   = res_index_q;
    load_out      = 1'b0;

    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          res_status_d = ST_OK;
          res_data_d   = '0;
          res_index_d  = '0;
          key_d        = s_axis_tdata;
          case (op_in)
            OP_PUSH: begin
              if (at_limit) begin
                res_status_d = ST_FAIL;
              end else begin
                // count stays below DEPTH here, so its low bits address the slot
                mem_we  = 1'b1;
                count_d = COUNT_W'(count_q + 1'b1);
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_status_d = ST_FAIL;
              end else begin
                mem_raddr = top_addr;
                count_d   = COUNT_W'(count_q - 1'b1);
              end
            end
            OP_PEEK: begin
              if (count_q == '0) begin
                res_status_d = ST_FAIL;
              end else begin
                mem_raddr = top_addr;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                res_status_d = ST_NOTFOUND;
              end else begin
                mem_raddr = top_addr;
                ptr_d     = top_addr;
              end
            end
            default: begin
              // unused opcode: no operation, report the flags only
            end
          endcase
        end
      end
      FSM_READ: begin
        res_data_d = rd_data_q;
      end
      FSM_SCAN: begin
        if (key_hit) begin
          res_index_d = INDEX_W'(ptr_q);
        end else if (ptr_q == '0) begin
          res_status_d = ST_NOTFOUND;
        end else begin
          // walk one entry down per cycle
          ptr_d     = ptr_q - 1'b1;
          mem_raddr = ptr_q - 1'b1;
        end
      end
      FSM_DONE: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // stack ram, up to one write and one read per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[ADDR_W-1:0]] <= s_axis_tdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      count_q   <= '0;
      cap_q     <= CAP_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_index_q  <= res_index_d;
    if (load_out) begin
      // count is already the post-operation value when the result is loaded
      m_status_q <= res_status_q;
      m_data_q   <= res_data_q;
      m_index_q  <= res_index_q;
      m_count_q  <= count_q;
      m_empty_q  <= (count_q == '0);
      m_full_q   <= at_limit;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {1'b0, m_full_q, m_empty_q, m_count_q, m_index_q, m_data_q};

endmodule

// ===== hw/rtl/bls_checker.sv =====
`include "assert_macros.svh"

module bls_checker
  import bls_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [47:0]         m_axis_tdata,
  input logic [STATUS_W-1:0] m_axis_tuser
);

  logic                  in_fire;
  logic                  out_fire;
  logic                  out_stall;
  logic [STATUS_W+47:0]  out_word;
  logic [1:0]            pend_q;
  logic [COUNT_W-1:0]    last_cnt_q;
  logic                  seen_q;
  logic [COUNT_W-1:0]    out_cnt;
  logic [COUNT_W-1:0]    cnt_up;
  logic [COUNT_W-1:0]    cnt_dn;
  logic                  cnt_ok;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};
  assign out_cnt   = m_axis_tdata[44:38];
  assign cnt_up    = COUNT_W'(last_cnt_q + 1'b1);
  assign cnt_dn    = COUNT_W'(last_cnt_q - 1'b1);
  assign cnt_ok    = (out_cnt == last_cnt_q) || (out_cnt == cnt_up) ||
                     (out_cnt == cnt_dn) || (out_cnt == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      last_cnt_q <= '0;
      seen_q     <= 1'b0;
    end else begin
      pend_q <= 2'(pend_q + {1'b0, in_fire} - {1'b0, out_fire});
      if (out_fire) begin
        last_cnt_q <= out_cnt;
        seen_q     <= 1'b1;
      end
    end
  end

  // a stalled result holds
  `BLS_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(out_word))

  // items are worked one at a time
  `BLS_ASSERT(a_one_in_flight, clk_i, rst_ni, in_fire |=> !s_axis_tready)

  // no result without an accepted item
  `BLS_ASSERT_MSG(a_no_extra_result, clk_i, rst_ni, out_fire |-> (pend_q != 2'd0), "result without item")

  // count stays, moves by one per item or drops to zero on clear
  `BLS_ASSERT_MSG(a_count_step, clk_i, rst_ni, out_fire && seen_q |-> cnt_ok, "count jumped")

endmodule

bind bounded_lifo_stack_with_search_core bls_checker u_bls_checker (.*);
